// ----- design/strongly_connected_components_core_defines.svh -----
// ----------------------------------------------------------------------------
// SCC core assertion macros
// Shared property macros for the checker of the SCC core.
// ----------------------------------------------------------------------------
`ifndef STRONGLY_CONNECTED_COMPONENTS_CORE_DEFINES_SVH
`define STRONGLY_CONNECTED_COMPONENTS_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scc check failed");

// Next-cycle implication, disabled during reset.
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scc check failed");

`endif

// ----- design/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// SCC package
// Sizes, storage word types and sequencer states of the SCC core.
// ----------------------------------------------------------------------------
`default_nettype none
package scc_pkg;
	localparam int NumVert   = 64;
	localparam int VertW     = 6;
	localparam int CntW      = 7;
	localparam int NumEdge   = 256;
	localparam int EdgeAw    = 8;
	localparam int EdgeCntW  = 9;

	typedef logic [VertW-1:0] vert_t;

	typedef struct packed {
		vert_t src;
		vert_t dst;
	} edge_t;

	typedef struct packed {
		vert_t ord;
		vert_t low;
	} vl_t;

	typedef struct packed {
		vert_t               v;
		logic [EdgeCntW-1:0] p;
	} frame_t;

	typedef struct packed {
		vert_t v;
		vert_t comp;
		logic  last;
	} res_t;

	typedef enum logic [3:0] {
		ST_LOAD, ST_ROOT, ST_SCAN_RD, ST_SCAN_CHK, ST_UPD, ST_POP,
		ST_POPC, ST_POPC2, ST_PARENT, ST_PAR2, ST_PAR3, ST_OUT_RD, ST_OUT_W
	} state_t;
endpackage
`default_nettype wire

// ----- design/scc_ram.sv -----
// ----------------------------------------------------------------------------
// SCC RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- design/strongly_connected_components_core.sv -----
// ----------------------------------------------------------------------------
// Strongly connected components core
// Loads a directed graph one edge per request, then runs Tarjan's algorithm.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one edge per request, one per cycle
//   while loading. The request with last set starts the walk; in_ready stays
//   low until every result of that graph has been taken.
//   Output channel (out_valid/out_ready): one result per vertex, in the order
//   components are popped; graph_end marks the final one and dropped_edges is
//   the same on every result of the graph.
//   Walk: each vertex rescans the edge memory from where it stopped,
//   reading then checking each entry; results then stream out one at a
//   time. The edge memory's one registered read sets the scan rate.
//   vertex_count must be written through cfg_we/cfg_wdata only while the
//   core is idle; the core does not enforce this. Reset clears all control
//   state and sets vertex_count to 64; no memory clearing pass is needed.
//   A stalled receiver holds the current result and halts the core; after
//   the last result all graph state is cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module strongly_connected_components_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [6:0]         cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [5:0]         source_vertex,
	input  wire logic [5:0]         target_vertex,
	input  wire logic               has_edge,
	input  wire logic               last,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [5:0]              vertex,
	output logic [5:0]              component,
	output logic                    component_end,
	output logic                    graph_end,
	output logic                    dropped_edges
);
	import scc_pkg::*;

	state_t              state_q, state_d;
	logic [CntW-1:0]     cfg_q, n_act;
	logic [EdgeCntW-1:0] etot_q, etot_d, cur_p_q, cur_p_d;
	logic [CntW-1:0]     root_q, root_d, vc_q, vc_d, cst_top_q, cst_top_d;
	logic [CntW-1:0]     fst_top_q, fst_top_d, prod_q, prod_d, oidx_q, oidx_d;
	vert_t               comp_q, comp_d, cur_v_q, cur_v_d;
	vert_t               cur_ord_q, cur_ord_d, cur_low_q, cur_low_d, clow_q, clow_d;
	logic                ovf_q, ovf_d;
	logic [NumVert-1:0]  vis_q, vis_d, onstk_q, onstk_d;

	logic                e_we, vl_we, cst_we, frm_we, res_we;
	logic [EdgeAw-1:0]   e_waddr;
	edge_t               e_wdata, e_rdata;
	vert_t               vl_waddr, vl_raddr, cst_waddr, frm_waddr, res_waddr;
	vl_t                 vl_wdata, vl_rdata;
	vert_t               cst_wdata, cst_rdata;
	frame_t              frm_wdata, frm_rdata;
	res_t                res_wdata, res_rdata;

	// Active vertex count: zero reads as one, capped at the vertex capacity
	always_comb begin
		if (cfg_q == '0) begin
			n_act = CntW'(1);
		end else if (cfg_q > CntW'(NumVert)) begin
			n_act = CntW'(NumVert);
		end else begin
			n_act = cfg_q;
		end
	end

	// Storage
	scc_ram #(.WIDTH($bits(edge_t)), .DEPTH(NumEdge)) u_edge_ram (
		.clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(cur_p_q[EdgeAw-1:0]), .rdata(e_rdata));
	scc_ram #(.WIDTH($bits(vl_t)), .DEPTH(NumVert)) u_vl_ram (
		.clk, .we(vl_we), .waddr(vl_waddr), .wdata(vl_wdata),
		.raddr(vl_raddr), .rdata(vl_rdata));
	scc_ram #(.WIDTH(VertW), .DEPTH(NumVert)) u_cst_ram (
		.clk, .we(cst_we), .waddr(cst_waddr), .wdata(cst_wdata),
		.raddr(VertW'(cst_top_q - CntW'(1))), .rdata(cst_rdata));
	scc_ram #(.WIDTH($bits(frame_t)), .DEPTH(NumVert)) u_frm_ram (
		.clk, .we(frm_we), .waddr(frm_waddr), .wdata(frm_wdata),
		.raddr(VertW'(fst_top_q - CntW'(1))), .rdata(frm_rdata));
	scc_ram #(.WIDTH($bits(res_t)), .DEPTH(NumVert)) u_res_ram (
		.clk, .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
		.raddr(oidx_q[VertW-1:0]), .rdata(res_rdata));

	// Vertex, component and component_end come straight from the held result read
	assign in_ready      = (state_q == ST_LOAD);
	assign out_valid     = (state_q == ST_OUT_W);
	assign vertex        = res_rdata.v;
	assign component     = res_rdata.comp;
	assign component_end = res_rdata.last;
	assign graph_end     = (oidx_q == prod_q - CntW'(1));
	assign dropped_edges = ovf_q;

	// Sequencer: next state, memory controls and register updates
	always_comb begin
		state_d   = state_q;
		etot_d    = etot_q;
		cur_p_d   = cur_p_q;
		root_d    = root_q;
		vc_d      = vc_q;
		cst_top_d = cst_top_q;
		fst_top_d = fst_top_q;
		prod_d    = prod_q;
		oidx_d    = oidx_q;
		comp_d    = comp_q;
		cur_v_d   = cur_v_q;
		cur_ord_d = cur_ord_q;
		cur_low_d = cur_low_q;
		clow_d    = clow_q;
		ovf_d     = ovf_q;
		vis_d     = vis_q;
		onstk_d   = onstk_q;
		e_we      = 1'b0;
		e_waddr   = etot_q[EdgeAw-1:0];
		e_wdata   = '{src: source_vertex, dst: target_vertex};
		vl_we     = 1'b0;
		vl_waddr  = cur_v_q;
		vl_wdata  = '{ord: cur_ord_q, low: cur_low_q};
		vl_raddr  = e_rdata.dst;
		cst_we    = 1'b0;
		cst_waddr = cst_top_q[VertW-1:0];
		cst_wdata = cur_v_q;
		frm_we    = 1'b0;
		frm_waddr = VertW'(fst_top_q - CntW'(1));
		frm_wdata = '{v: cur_v_q, p: cur_p_q + EdgeCntW'(1)};
		res_we    = 1'b0;
		res_waddr = prod_q[VertW-1:0];
		res_wdata = '{v: cst_rdata, comp: comp_q, last: (cst_rdata == cur_v_q)};

		case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					if (has_edge) begin
						if (etot_q >= EdgeCntW'(NumEdge) ||
						    {1'b0, source_vertex} >= n_act ||
						    {1'b0, target_vertex} >= n_act) begin
							ovf_d = 1'b1;
						end else begin
							e_we   = 1'b1;
							etot_d = etot_q + EdgeCntW'(1);
						end
					end
					if (last) begin
						root_d  = '0;
						state_d = ST_ROOT;
					end
				end
			end
			ST_ROOT: begin
				if (root_q == n_act) begin
					oidx_d  = '0;
					state_d = ST_OUT_RD;
				end else if (vis_q[root_q[VertW-1:0]]) begin
					root_d = root_q + CntW'(1);
				end else begin
					// enter root vertex
					vis_d[root_q[VertW-1:0]]   = 1'b1;
					onstk_d[root_q[VertW-1:0]] = 1'b1;
					vl_we     = 1'b1;
					vl_waddr  = root_q[VertW-1:0];
					vl_wdata  = '{ord: vc_q[VertW-1:0], low: vc_q[VertW-1:0]};
					cst_we    = 1'b1;
					cst_wdata = root_q[VertW-1:0];
					cst_top_d = cst_top_q + CntW'(1);
					cur_v_d   = root_q[VertW-1:0];
					cur_p_d   = '0;
					cur_ord_d = vc_q[VertW-1:0];
					cur_low_d = vc_q[VertW-1:0];
					vc_d      = vc_q + CntW'(1);
					fst_top_d = CntW'(1);
					state_d   = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				state_d = (cur_p_q == etot_q) ? ST_POP : ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				cur_p_d = cur_p_q + EdgeCntW'(1);
				state_d = ST_SCAN_RD;
				if (e_rdata.src == cur_v_q) begin
					if ({1'b0, e_rdata.dst} >= n_act) begin
						ovf_d = 1'b1;
					end else if (!vis_q[e_rdata.dst]) begin
						// save current frame, enter the target
						frm_we    = 1'b1;
						vis_d[e_rdata.dst]   = 1'b1;
						onstk_d[e_rdata.dst] = 1'b1;
						vl_we     = 1'b1;
						vl_waddr  = e_rdata.dst;
						vl_wdata  = '{ord: vc_q[VertW-1:0], low: vc_q[VertW-1:0]};
						cst_we    = 1'b1;
						cst_wdata = e_rdata.dst;
						cst_top_d = cst_top_q + CntW'(1);
						cur_v_d   = e_rdata.dst;
						cur_p_d   = '0;
						cur_ord_d = vc_q[VertW-1:0];
						cur_low_d = vc_q[VertW-1:0];
						vc_d      = vc_q + CntW'(1);
						fst_top_d = fst_top_q + CntW'(1);
					end else if (onstk_q[e_rdata.dst]) begin
						state_d = ST_UPD;
					end
				end
			end
			ST_UPD: begin
				if (vl_rdata.ord < cur_low_q) begin
					cur_low_d = vl_rdata.ord;
					vl_we     = 1'b1;
					vl_wdata  = '{ord: cur_ord_q, low: vl_rdata.ord};
				end
				state_d = ST_SCAN_RD;
			end
			ST_POP: begin
				fst_top_d = fst_top_q - CntW'(1);
				state_d   = (cur_low_q == cur_ord_q) ? ST_POPC : ST_PARENT;
			end
			ST_POPC: begin
				state_d = ST_POPC2;
			end
			ST_POPC2: begin
				cst_top_d          = cst_top_q - CntW'(1);
				onstk_d[cst_rdata] = 1'b0;
				res_we             = 1'b1;
				prod_d             = prod_q + CntW'(1);
				if (cst_rdata != cur_v_q && cst_top_q != CntW'(1)) begin
					state_d = ST_POPC;
				end else begin
					comp_d  = comp_q + VertW'(1);
					state_d = ST_PARENT;
				end
			end
			ST_PARENT: begin
				state_d = (fst_top_q == '0) ? ST_ROOT : ST_PAR2;
			end
			ST_PAR2: begin
				vl_raddr = frm_rdata.v;
				clow_d   = cur_low_q;
				cur_v_d  = frm_rdata.v;
				cur_p_d  = frm_rdata.p;
				state_d  = ST_PAR3;
			end
			ST_PAR3: begin
				cur_ord_d = vl_rdata.ord;
				cur_low_d = vl_rdata.low;
				if (clow_q < vl_rdata.low) begin
					cur_low_d = clow_q;
					vl_we     = 1'b1;
					vl_wdata  = '{ord: vl_rdata.ord, low: clow_q};
				end
				state_d = ST_SCAN_RD;
			end
			ST_OUT_RD: begin
				state_d = ST_OUT_W;
			end
			ST_OUT_W: begin
				if (out_ready) begin
					if (graph_end) begin
						// clear graph state
						etot_d    = '0;
						vc_d      = '0;
						cst_top_d = '0;
						fst_top_d = '0;
						prod_d    = '0;
						comp_d    = '0;
						ovf_d     = 1'b0;
						vis_d     = '0;
						onstk_d   = '0;
						state_d   = ST_LOAD;
					end else begin
						oidx_d  = oidx_q + CntW'(1);
						state_d = ST_OUT_RD;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cfg_q     <= CntW'(NumVert);
			etot_q    <= '0;
			root_q    <= '0;
			vc_q      <= '0;
			cst_top_q <= '0;
			fst_top_q <= '0;
			prod_q    <= '0;
			oidx_q    <= '0;
			comp_q    <= '0;
			ovf_q     <= 1'b0;
			vis_q     <= '0;
			onstk_q   <= '0;
		end else begin
			state_q   <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			etot_q    <= etot_d;
			root_q    <= root_d;
			vc_q      <= vc_d;
			cst_top_q <= cst_top_d;
			fst_top_q <= fst_top_d;
			prod_q    <= prod_d;
			oidx_q    <= oidx_d;
			comp_q    <= comp_d;
			ovf_q     <= ovf_d;
			vis_q     <= vis_d;
			onstk_q   <= onstk_d;
		end
	end

	// Current frame working registers
	always_ff @(posedge clk) begin
		cur_p_q   <= cur_p_d;
		cur_v_q   <= cur_v_d;
		cur_ord_q <= cur_ord_d;
		cur_low_q <= cur_low_d;
		clow_q    <= clow_d;
	end
endmodule
`default_nettype wire

// ----- design/scc_checker.sv -----
// ----------------------------------------------------------------------------
// SCC port checker
// Port-level checks of the SCC core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "strongly_connected_components_core_defines.svh"
module scc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       last,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [5:0] vertex,
	input wire logic       graph_end
);
	// loading and result delivery never overlap
	`SCC_ASSERT_IMPL(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// the final request closes the input until results are done
	`SCC_ASSERT_NEXT(a_last_closes, clk, arst_n, in_valid && in_ready && last, !in_ready)
	// a stalled result holds
	`SCC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(vertex) && $stable(graph_end))
	// nothing follows the end of a graph
	`SCC_ASSERT_NEXT(a_end, clk, arst_n, out_valid && out_ready && graph_end, !out_valid)
endmodule

bind strongly_connected_components_core scc_checker u_scc_checker (
	.clk, .arst_n, .in_valid, .in_ready, .last, .out_valid, .out_ready,
	.vertex, .graph_end);
`default_nettype wire
